### rtl/wfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_pkg - shared types and codes of the WebSocket frame deframer
// Result kinds and the result record passed from the parser to the output stage.
// ----------------------------------------------------------------------------
package wfd_pkg;

  localparam int unsigned LimitW = 31;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_BAD_HDR   = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } result_t;

endpackage

### rtl/wfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_parser - frame header parser and payload unmasker
// Advances the parse state by one byte per accepted beat and forms the result.
// ----------------------------------------------------------------------------
module wfd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  in_byte,
  input  logic [wfd_pkg::LimitW-1:0]  max_len,
  output logic                        res_valid,
  output wfd_pkg::result_t            res
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [2:0] NEED_16     = 3'd2;
  localparam logic [2:0] NEED_64     = 3'd0; // eight bytes, count wraps
  localparam logic [2:0] NEED_KEY    = 3'd4;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam int unsigned LW = wfd_pkg::LimitW;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      hdr_r, hdr_nxt;
  logic [LW-1:0]   len_r, len_nxt;    // low bits of the frame length
  logic            ovf_r, ovf_nxt;    // some length bit above the low field is set
  logic [2:0]      cnt_r, cnt_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [LW-1:0]   idx_r, idx_nxt;

  logic [2:0]      cnt_inc;
  logic [LW-1:0]   chk_len;
  logic            chk_ovf;
  logic            too_long;
  logic            op_known;
  logic            bad_hdr;
  logic [LW:0]     idx_plus;
  logic            pay_last;
  logic [7:0]      key_byte;
  logic [2:0]      len_need;

  // shared length check
  assign too_long = chk_ovf || (chk_len > max_len);
  assign cnt_inc  = cnt_r + 3'd1;
  assign len_need = (phase_r == PH_LEN16) ? NEED_16 : NEED_64;

  assign op_known = (hdr_r[3:0] == OP_CONT)  || (hdr_r[3:0] == OP_TEXT) ||
                    (hdr_r[3:0] == OP_BIN)   || (hdr_r[3:0] == OP_CLOSE) ||
                    (hdr_r[3:0] == OP_PING)  || (hdr_r[3:0] == OP_PONG);
  assign bad_hdr  = (hdr_r[6:4] != 3'd0) || !in_byte[7] || !op_known;

  // payload byte position and mask key lane
  assign idx_plus = {1'b0, idx_r} + {{LW{1'b0}}, 1'b1};
  assign pay_last = (idx_plus == {1'b0, len_r});

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state and result
  always_comb begin
    phase_nxt     = phase_r;
    hdr_nxt       = hdr_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    chk_len       = len_r;
    chk_ovf       = ovf_r;
    res_valid     = 1'b0;
    res.kind      = wfd_pkg::KIND_PAYLOAD;
    res.data_byte = 8'd0;
    res.opcode    = hdr_r[3:0];
    res.fin       = hdr_r[7];
    res.last      = 1'b0;
    unique case (phase_r)
      PH_HDR1: begin
        chk_len = {{(LW-7){1'b0}}, in_byte[6:0]};
        chk_ovf = 1'b0;
        if (bad_hdr) begin
          phase_nxt = PH_HDR0;
          res_valid = 1'b1;
          res.kind  = wfd_pkg::KIND_BAD_HDR;
        end else begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          cnt_nxt = 3'd0;
          if (in_byte[6:0] == LEN_CODE_16) begin
            phase_nxt = PH_LEN16;
          end else if (in_byte[6:0] == LEN_CODE_64) begin
            phase_nxt = PH_LEN64;
          end else begin
            len_nxt = chk_len;
            if (too_long) begin
              phase_nxt = PH_HDR0;
              res_valid = 1'b1;
              res.kind  = wfd_pkg::KIND_TOO_LARGE;
            end else begin
              phase_nxt = PH_MASK;
            end
          end
        end
      end
      PH_LEN16, PH_LEN64: begin
        chk_len = {len_r[LW-9:0], in_byte};
        chk_ovf = ovf_r || (len_r[LW-1:LW-8] != 8'd0);
        len_nxt = chk_len;
        ovf_nxt = chk_ovf;
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_need) begin
          cnt_nxt = 3'd0;
          if (too_long) begin
            phase_nxt = PH_HDR0;
            res_valid = 1'b1;
            res.kind  = wfd_pkg::KIND_TOO_LARGE;
          end else begin
            phase_nxt = PH_MASK;
          end
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], in_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc == NEED_KEY) begin
          if ((len_r == '0) && !ovf_r) begin
            phase_nxt = PH_HDR0;
            res_valid = 1'b1;
            res.kind  = wfd_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
            idx_nxt   = '0;
          end
        end
      end
      PH_DATA: begin
        res_valid     = 1'b1;
        res.kind      = wfd_pkg::KIND_PAYLOAD;
        res.data_byte = in_byte ^ key_byte;
        res.last      = pay_last;
        if (pay_last) begin
          phase_nxt = PH_HDR0;
        end else begin
          idx_nxt = idx_plus[LW-1:0];
        end
      end
      default: begin
        hdr_nxt   = in_byte;
        phase_nxt = PH_HDR1;
      end
    endcase
  end

  // hold parse state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hdr_r   <= 8'd0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      cnt_r   <= 3'd0;
      key_r   <= 32'd0;
      idx_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### rtl/wfd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_out_stage - result register
// Holds one result beat and frees the input side as it drains.
// ----------------------------------------------------------------------------
module wfd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              res_valid,
  input  wfd_pkg::result_t  res,
  output logic              out_valid,
  input  logic              out_ready,
  output wfd_pkg::result_t  out_res
);

  logic             valid_r;
  wfd_pkg::result_t res_r;
  logic             step;

  assign in_ready  = !valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // load a result on each accepted beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_r <= res;
    end
  end

endmodule

### rtl/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top - WebSocket receive frame parser
// Parses frame headers from a byte stream and emits unmasked payload bytes.
//
//   channel   | direction | contents
//   ----------+-----------+----------------------------------------------
//   in_       | slave     | tdata[7:0] received byte
//   out_      | master    | tdata data/opcode/fin, tuser kind, tlast
//   cfg_      | write     | wr_data[30:0] max_frame_length
//
// One byte per cycle unless a held result stalls the input: each beat updates the parse state in one pass and its
// result, if any, lands in the output register the next cycle.
// Reset clears the parse state; the length limit resets to 2147483647.
// in_tready is low only while a held result beat is not taken.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [7:0] data_byte, [11:8] frame_opcode,
                                                  // [12] final_fragment, [15:13] zero
  output logic [1:0]                  out_tuser,  // [1:0] result_kind
  output logic                        out_tlast,  // last_of_frame
  input  logic                        cfg_wr_en,
  input  logic [wfd_pkg::LimitW-1:0]  cfg_wr_data
);

  logic [wfd_pkg::LimitW-1:0] max_len_r;
  logic                       step;
  logic                       res_valid;
  wfd_pkg::result_t           res;
  wfd_pkg::result_t           out_res;

  assign step = in_tvalid && in_tready;

  // length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '1;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  wfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_byte   (in_tdata),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  wfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack the result beat
  assign out_tdata = {3'b000, out_res.fin, out_res.opcode, out_res.data_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the WebSocket receive frame deframer
// Feeds frame streams byte by byte, short directed frames first, then random
// well-formed frames mixed with broken headers and noise under several length
// limits. A built-in frame parser predicts every result beat, and the beats
// leaving the block are checked field by field against that prediction.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum logic [2:0] {
    WAIT_HDR0   = 3'd0,
    WAIT_HDR1   = 3'd1,
    GET_LEN16   = 3'd2,
    GET_LEN64   = 3'd3,
    GET_KEY     = 3'd4,
    GET_PAYLOAD = 3'd5
  } parse_phase_t;

  typedef enum int {
    ENC_SHORT,
    ENC_EXT16,
    ENC_EXT64
  } len_enc_t;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;       // [7:0] in_byte
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic [15:0] out_tdata;              // [7:0] data_byte, [11:8] frame_opcode,
                                       // [12] final_fragment, [15:13] zero
  logic [1:0] out_tuser;               // [1:0] result_kind
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [wfd_pkg::LimitW-1:0] cfg_wr_data = '0;

  // Parser state of the predictor
  parse_phase_t hdr_phase = WAIT_HDR0;
  logic [7:0] hdr_byte0 = 8'h00;
  logic [63:0] frame_len = 64'd0;
  logic [2:0] field_cnt = 3'd0;
  logic [31:0] mask_key = 32'd0;
  logic [30:0] payload_idx = 31'd0;
  logic [30:0] length_limit = LIMIT_MAX;

  wfd_pkg::result_t expected_results[$];
  int fails = 0;
  int sent_count = 0;
  bit tx_busy = 1'b1;
  bit rx_busy = 1'b1;
  int rx_hold = 0;

  websocket_frame_deframer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit opcode_known(input logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
           op == OP_CLOSE || op == OP_PING || op == OP_PONG;
  endfunction

  function automatic wfd_pkg::result_t make_result(input wfd_pkg::kind_t k,
                                                   input logic [7:0] d,
                                                   input logic l);
    wfd_pkg::result_t r;
    r.kind      = k;
    r.data_byte = d;
    r.opcode    = hdr_byte0[3:0];
    r.fin       = hdr_byte0[7];
    r.last      = l;
    return r;
  endfunction

  // Compare the finished length against the limit; reject or move to the key
  function automatic bit close_length(output wfd_pkg::result_t r);
    r = '0;
    if (frame_len > 64'(length_limit)) begin
      hdr_phase = WAIT_HDR0;
      r = make_result(wfd_pkg::KIND_TOO_LARGE, 8'h00, 1'b0);
      return 1'b1;
    end
    hdr_phase = GET_KEY;
    field_cnt = 3'd0;
    mask_key  = 32'd0;
    return 1'b0;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte yields a result
  function automatic bit predict_byte(input logic [7:0] b, output wfd_pkg::result_t r);
    logic [7:0] key;
    logic       last_byte;
    r = '0;
    case (hdr_phase)
      WAIT_HDR1: begin
        if (hdr_byte0[6:4] != 3'd0 || !b[7] || !opcode_known(hdr_byte0[3:0])) begin
          hdr_phase = WAIT_HDR0;
          r = make_result(wfd_pkg::KIND_BAD_HDR, 8'h00, 1'b0);
          return 1'b1;
        end
        frame_len = 64'd0;
        field_cnt = 3'd0;
        if (b[6:0] == LEN_EXT16) begin
          hdr_phase = GET_LEN16;
        end else if (b[6:0] == LEN_EXT64) begin
          hdr_phase = GET_LEN64;
        end else begin
          frame_len = 64'(b[6:0]);
          return close_length(r);
        end
      end
      GET_LEN16, GET_LEN64: begin
        frame_len = {frame_len[55:0], b};
        field_cnt = field_cnt + 3'd1;
        // eight length bytes wrap the 3-bit count back to zero
        if (field_cnt == ((hdr_phase == GET_LEN16) ? 3'd2 : 3'd0))
          return close_length(r);
      end
      GET_KEY: begin
        mask_key  = {mask_key[23:0], b};
        field_cnt = field_cnt + 3'd1;
        if (field_cnt == 3'd4) begin
          if (frame_len == 64'd0) begin
            hdr_phase = WAIT_HDR0;
            r = make_result(wfd_pkg::KIND_EMPTY, 8'h00, 1'b1);
            return 1'b1;
          end
          hdr_phase   = GET_PAYLOAD;
          payload_idx = 31'd0;
        end
      end
      GET_PAYLOAD: begin
        key = mask_key[8 * (3 - payload_idx[1:0]) +: 8];
        last_byte = (64'(payload_idx) + 64'd1 == frame_len);
        if (last_byte)
          hdr_phase = WAIT_HDR0;
        else
          payload_idx = payload_idx + 31'd1;
        r = make_result(wfd_pkg::KIND_PAYLOAD, b ^ key, last_byte);
        return 1'b1;
      end
      default: begin
        hdr_byte0 = b;
        hdr_phase = WAIT_HDR1;
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- handshakes

  // Idle gaps occur in busy stretches only, none in calm stretches
  function automatic int draw_gap(inout bit busy);
    if ($urandom_range(0, 39) == 0)
      busy = !busy;
    return busy ? $urandom_range(0, 18) : 0;
  endfunction

  // Drive one byte, hold it until accepted, then predict its result
  task automatic send_byte(input logic [7:0] b);
    int gap;
    wfd_pkg::result_t r;
    gap = draw_gap(tx_busy);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_byte(b, r))
      expected_results.push_back(r);
    sent_count++;
  endtask

  // Stop sending and let every expected beat arrive
  task automatic wait_for_results();
    if (in_tvalid)
      in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [30:0] v);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    length_limit = v;
  endtask

  // Feed random bytes until the parser is back at a header
  task automatic flush_frame();
    while (hdr_phase != WAIT_HDR0)
      send_byte(8'($urandom));
  endtask

  // Send header and length; key and payload only if the parser still wants them
  task automatic send_frame(input bit fin, input logic [2:0] rsv, input logic [3:0] op,
                            input bit masked, input logic [63:0] len,
                            input len_enc_t enc, input logic [31:0] key);
    int i;
    send_byte({fin, rsv, op});
    case (enc)
      ENC_EXT16: send_byte({masked, LEN_EXT16});
      ENC_EXT64: send_byte({masked, LEN_EXT64});
      default:   send_byte({masked, len[6:0]});
    endcase
    if (hdr_phase == GET_LEN16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (hdr_phase == GET_LEN64) begin
      for (i = 7; i >= 0; i--)
        send_byte(len[8 * i +: 8]);
    end
    if (hdr_phase == GET_KEY)
      for (i = 3; i >= 0; i--)
        send_byte(key[8 * i +: 8]);
    while (hdr_phase == GET_PAYLOAD)
      send_byte(8'($urandom));
  endtask

  // Stall the result side after accepted beats
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      if (rx_hold == 0)
        out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      rx_hold = draw_gap(rx_busy);
      if (rx_hold != 0)
        out_tready <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    wfd_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tuser %0d tdata %h",
               out_tuser, out_tdata);
        fails++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, out_tuser);
        check_field("data_byte", want.data_byte, out_tdata[7:0]);
        check_field("frame_opcode", want.opcode, out_tdata[11:8]);
        check_field("final_fragment", want.fin, out_tdata[12]);
        check_field("last_of_frame", want.last, out_tlast);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [3:0] pick_known_op();
    case ($urandom_range(0, 5))
      0: return OP_CONT;
      1: return OP_TEXT;
      2: return OP_BINARY;
      3: return OP_CLOSE;
      4: return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  function automatic logic [3:0] pick_unknown_op();
    logic [3:0] op;
    do op = 4'($urandom); while (opcode_known(op));
    return op;
  endfunction

  // Mostly short payloads; the limit (or 126..300), one past it, huge and zero
  function automatic logic [63:0] pick_length(input logic [30:0] lim);
    int unsigned cap;
    cap = (lim < 31'd24) ? 32'(lim) : 24;
    case ($urandom_range(0, 9))
      6: return (lim <= 31'd300) ? 64'(lim) : 64'($urandom_range(126, 300));
      7: return 64'(lim) + 64'd1;
      8: return {1'b1, 31'($urandom), 32'($urandom)};
      9: return 64'd0;
      default: return 64'($urandom_range(0, cap));
    endcase
  endfunction

  function automatic len_enc_t pick_encoding(input logic [63:0] len);
    if (len > 64'd65535)
      return ENC_EXT64;
    if (len >= 64'd126)
      return ($urandom_range(0, 1) != 0) ? ENC_EXT16 : ENC_EXT64;
    case ($urandom_range(0, 5))
      4: return ENC_EXT16;
      5: return ENC_EXT64;
      default: return ENC_SHORT;
    endcase
  endfunction

  task automatic test_empty_frame();
    send_frame(1'b1, 3'd0, OP_PING, 1'b1, 64'd0, ENC_SHORT, 32'h0000_0000);
  endtask

  // Five bytes wrap the four-byte key; 16-bit length form
  task automatic test_masked_payload();
    send_frame(1'b0, 3'd0, OP_TEXT, 1'b1, 64'd5, ENC_EXT16, 32'hFF00_A55A);
  endtask

  task automatic test_bad_headers();
    send_frame(1'b1, 3'b111, OP_TEXT, 1'b1, 64'd1, ENC_SHORT, 32'd0);
    send_frame(1'b1, 3'd0, OP_BINARY, 1'b0, 64'd5, ENC_SHORT, 32'd0);
    send_frame(1'b1, 3'b111, 4'hF, 1'b1, 64'd0, ENC_EXT64, 32'd0);
  endtask

  // One past the limit is rejected and the following bytes parse as headers
  task automatic test_length_limit();
    set_limit(31'd3);
    send_frame(1'b1, 3'd0, OP_CLOSE, 1'b1, 64'd4, ENC_SHORT, 32'd0);
    send_byte(8'h81);
    send_byte(8'h83);
    flush_frame();
    send_frame(1'b0, 3'd0, OP_CONT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ENC_EXT64, 32'd0);
  endtask

  task automatic run_random_phase(input logic [30:0] lim, input int n_bytes,
                                  input bit noise_ok);
    int start;
    int unsigned sel;
    logic [63:0] len;
    set_limit(lim);
    start = sent_count;
    while (sent_count - start < n_bytes) begin
      sel = $urandom_range(0, 19);
      if (sel == 0 && noise_ok) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        flush_frame();
      end else if (sel <= 2) begin
        len = 64'($urandom_range(0, 127));
        case ($urandom_range(0, 2))
          0: send_frame(1'($urandom), 3'($urandom_range(1, 7)), pick_known_op(),
                        1'b1, len, ENC_SHORT, 32'($urandom));
          1: send_frame(1'($urandom), 3'($urandom), 4'($urandom), 1'b0, len,
                        ENC_SHORT, 32'($urandom));
          default: send_frame(1'($urandom), 3'($urandom), pick_unknown_op(), 1'b1,
                              len, ENC_SHORT, 32'($urandom));
        endcase
      end else if (sel == 3) begin
        wait_for_results();
      end else begin
        len = pick_length(lim);
        send_frame(1'($urandom), 3'd0, pick_known_op(), 1'b1, len,
                   pick_encoding(len), 32'($urandom));
      end
    end
    wait_for_results();
  endtask

  task automatic test_random();
    run_random_phase(LIMIT_MAX, 200, 1'b0);
    run_random_phase(31'd0, 120, 1'b1);
    run_random_phase(31'($urandom_range(1, 24)), 200, 1'b1);
    run_random_phase(31'($urandom_range(126, 400)), 200, 1'b1);
    run_random_phase(31'($urandom), 180, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_frame();
    test_masked_payload();
    test_bad_headers();
    test_length_limit();
    test_random();
    wait_for_results();
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/wfd_pkg.sv
rtl/wfd_parser.sv
rtl/wfd_out_stage.sv
rtl/websocket_frame_deframer_top.sv
tb/tb_top.sv
